### rtl/rmsn_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rmsn_pkg
// Shared constants, codes and types of the RMS row normaliser.
// ============================================================================
package rmsn_pkg;

   // Default upper bound on the row length
   localparam int unsigned MAX_ROW_LEN_DEFAULT = 65536;

   // Register reset values
   localparam logic [16:0] ROW_LENGTH_RESET = 17'd4096;
   localparam logic [31:0] EPSILON_RESET    = 32'h358637BD;

   // Register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_ROW_LENGTH  = 2'd0;
   localparam logic [1:0] REG_DATA_FORMAT = 2'd1;
   localparam logic [1:0] REG_EPSILON     = 2'd2;

   // Element formats
   localparam logic FORMAT_FP32 = 1'b0;
   localparam logic FORMAT_BF16 = 1'b1;

   // Item operations
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_NORMALIZE  = 1'b1;

   // Floating point constants
   localparam logic [31:0] FP32_ONE   = 32'h3F800000;
   localparam logic [31:0] CANON_NAN  = 32'h7FC00000;
   localparam logic [31:0] POS_INF    = 32'h7F800000;
   localparam logic [31:0] NEG_INF    = 32'hFF800000;
   localparam logic [31:0] POS_ZERO   = 32'h00000000;
   localparam logic [31:0] NEG_ZERO   = 32'h80000000;
   localparam logic [15:0] BF16_NAN   = 16'h7FC0;

   // Operations of the shared arithmetic unit
   localparam logic [2:0] FPU_MUL  = 3'd0;
   localparam logic [2:0] FPU_ADD  = 3'd1;
   localparam logic [2:0] FPU_DIV  = 3'd2;
   localparam logic [2:0] FPU_SQRT = 3'd3;
   localparam logic [2:0] FPU_I2F  = 3'd4;

   // One queued item, element already widened to fp32
   typedef struct packed {
      logic        operation;
      logic [31:0] x;
      logic [31:0] gamma;
   } item_type;

   // Request to the arithmetic unit
   typedef struct packed {
      logic        start;
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   // Response of the arithmetic unit
   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } fpu_rsp_type;

   // True for any fp32 NaN pattern
   function automatic logic is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

endpackage

### rtl/rmsn_channels.sv
`timescale 1ns / 1ps
// ============================================================================
// rmsn channels
// Valid/ready channel bundles for request items and result items.
// ============================================================================
interface rmsn_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] element_bits;
   logic [31:0] gamma_bits;
   modport source (output valid, operation, element_bits, gamma_bits, input ready);
   modport sink   (input valid, operation, element_bits, gamma_bits, output ready);
endinterface

interface rmsn_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_bits;
   logic        row_last;
   modport source (output valid, result_bits, row_last, input ready);
   modport sink   (input valid, result_bits, row_last, output ready);
endinterface

### rtl/rmsn_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rmsn_front
// Accepts request items, widens bf16 elements to fp32 and pushes them on.
// ============================================================================
module rmsn_front (
   rmsn_req_if.sink           req_port,
   input  logic               data_format,
   input  logic               queue_full,
   output logic               push,
   output rmsn_pkg::item_type push_item
);

   // Accept whenever the queue has room.
   assign req_port.ready = !queue_full;
   assign push           = req_port.valid && !queue_full;

   // bf16 sits in the low half; it becomes the upper half of an fp32.
   always_comb begin
      push_item.operation = req_port.operation;
      push_item.gamma     = req_port.gamma_bits;
      if (data_format == rmsn_pkg::FORMAT_BF16) begin
         push_item.x = {req_port.element_bits[15:0], 16'h0000};
      end else begin
         push_item.x = req_port.element_bits;
      end
   end

endmodule

### rtl/rmsn_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rmsn_queue
// Two-entry item queue between the front and the back.
// ============================================================================
module rmsn_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rmsn_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output rmsn_pkg::item_type head_item
);

   rmsn_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/rmsn_fpu.sv
`timescale 1ns / 1ps
// ============================================================================
// rmsn_fpu
// Shared fp32 unit: multiply, add, divide, square root and integer convert,
// all rounded to nearest even with subnormals kept.
// ============================================================================
module rmsn_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  rmsn_pkg::fpu_req_type fpu_req,
   output rmsn_pkg::fpu_rsp_type fpu_rsp
);

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_ITER  = 3'd1;
   localparam logic [2:0] F_NORM  = 3'd2;
   localparam logic [2:0] F_ROUND = 3'd3;
   localparam logic [2:0] F_DONE  = 3'd4;

   localparam logic [6:0] DIV_STEPS  = 7'd80;
   localparam logic [6:0] SQRT_STEPS = 7'd40;

   typedef struct packed {
      logic               sign;
      logic signed [11:0] e;
      logic [23:0]        mant;
      logic               zero;
      logic               inf;
      logic               nan;
   } unpacked_type;

   // Value = mant * 2^e.
   function automatic unpacked_type unpack(input logic [31:0] v);
      unpacked_type u;
      u.sign = v[31];
      u.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
      u.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
      u.zero = (v[30:0] == 31'd0);
      if (v[30:23] == 8'd0) begin
         u.mant = {1'b0, v[22:0]};
         u.e    = -12'sd149;
      end else begin
         u.mant = {1'b1, v[22:0]};
         u.e    = $signed({4'b0000, v[30:23]}) - 12'sd150;
      end
      return u;
   endfunction

   logic [2:0]         fstate_ff, fstate_in;
   logic [31:0]        res_ff, res_in;
   logic               sign_ff, sign_in;
   logic signed [11:0] e_ff, e_in;
   logic [79:0]        mant_ff, mant_in;
   logic               sticky_ff, sticky_in;
   logic [79:0]        num_ff, num_in;
   logic [43:0]        rem_ff, rem_in;
   logic [23:0]        div_ff, div_in;
   logic               is_sqrt_ff, is_sqrt_in;
   logic [6:0]         count_ff, count_in;
   logic signed [13:0] s_ff, s_in;

   // Set-up work
   unpacked_type       ua, ub, big, little;
   logic               sx;
   logic signed [11:0] d;
   logic [49:0]        big50, sm50, sh50, mask50;
   logic               stk50;
   logic [50:0]        sum51;
   logic [47:0]        prod48;
   logic [24:0]        sq_mant;
   logic signed [11:0] sq_e;

   // Iteration
   logic [43:0] rem_sh, trial;
   logic        ge;

   // Normalise
   logic [6:0]         p;
   logic signed [13:0] s_lead, s_sub;

   // Round
   logic [79:0]        sh, rmask;
   logic               guard, stk;
   logic [24:0]        m25;
   logic signed [13:0] fe, field;
   logic [6:0]         rs;
   logic [4:0]         ls;

   always_comb begin
      fstate_in  = fstate_ff;
      res_in     = res_ff;
      sign_in    = sign_ff;
      e_in       = e_ff;
      mant_in    = mant_ff;
      sticky_in  = sticky_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      is_sqrt_in = is_sqrt_ff;
      count_in   = count_ff;
      s_in       = s_ff;

      ua     = unpack(fpu_req.a);
      ub     = unpack(fpu_req.b);
      sx     = ua.sign ^ ub.sign;
      prod48 = ua.mant * ub.mant;
      big    = (fpu_req.a[30:0] >= fpu_req.b[30:0]) ? ua : ub;
      little = (fpu_req.a[30:0] >= fpu_req.b[30:0]) ? ub : ua;
      d      = big.e - little.e;
      big50  = {big.mant, 26'd0};
      sm50   = {little.mant, 26'd0};
      mask50 = (50'd1 << d[5:0]) - 50'd1;
      if (d >= 12'sd50) begin
         sh50  = 50'd0;
         stk50 = 1'b1;
      end else begin
         sh50  = sm50 >> d[5:0];
         stk50 = |(sm50 & mask50);
      end
      if (big.sign == little.sign) begin
         sum51 = {1'b0, big50} + {1'b0, sh50[49:1], sh50[0] | stk50};
      end else begin
         sum51 = {1'b0, big50} - {1'b0, sh50[49:1], sh50[0] | stk50};
      end
      if (ua.e[0]) begin
         sq_mant = {ua.mant, 1'b0};
         sq_e    = ua.e - 12'sd1;
      end else begin
         sq_mant = {1'b0, ua.mant};
         sq_e    = ua.e;
      end

      if (is_sqrt_ff) begin
         rem_sh = {rem_ff[41:0], num_ff[79:78]};
         trial  = {mant_ff[41:0], 2'b01};
      end else begin
         rem_sh = {rem_ff[42:0], num_ff[79]};
         trial  = {20'd0, div_ff};
      end
      ge = (rem_sh >= trial);

      p = 7'd0;
      for (int i = 0; i < 80; i++) begin
         if (mant_ff[i]) begin
            p = 7'(i);
         end
      end
      s_lead = $signed({7'd0, p}) - 14'sd23;
      s_sub  = -14'sd149 - $signed({{2{e_ff[11]}}, e_ff});

      rs    = s_ff[6:0];
      ls    = 5'(-s_ff);
      rmask = (80'd1 << (rs - 7'd1)) - 80'd1;
      if (s_ff > 14'sd80) begin
         sh    = 80'd0;
         guard = 1'b0;
         stk   = sticky_ff | (|mant_ff);
      end else if (s_ff > 14'sd0) begin
         sh    = mant_ff >> rs;
         guard = mant_ff[rs - 7'd1];
         stk   = sticky_ff | (|(mant_ff & rmask));
      end else begin
         sh    = mant_ff << ls;
         guard = 1'b0;
         stk   = sticky_ff;
      end
      m25   = {1'b0, sh[23:0]} + 25'(guard & (stk | sh[0]));
      fe    = $signed({{2{e_ff[11]}}, e_ff}) + s_ff + 14'sd150;
      field = 14'sd0;

      unique case (fstate_ff)
         // Specials, set-up, or start of an iteration.
         F_IDLE: begin
            if (fpu_req.start) begin
               sticky_in  = 1'b0;
               is_sqrt_in = (fpu_req.op == rmsn_pkg::FPU_SQRT);
               rem_in     = 44'd0;
               fstate_in  = F_NORM;
               unique case (fpu_req.op)
                  rmsn_pkg::FPU_MUL: begin
                     sign_in = sx;
                     e_in    = ua.e + ub.e;
                     mant_in = {32'd0, prod48};
                     if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
                        res_in    = rmsn_pkg::CANON_NAN;
                        fstate_in = F_DONE;
                     end else if (ua.inf || ub.inf) begin
                        res_in    = {sx, rmsn_pkg::POS_INF[30:0]};
                        fstate_in = F_DONE;
                     end else if (ua.zero || ub.zero) begin
                        res_in    = {sx, 31'd0};
                        fstate_in = F_DONE;
                     end
                  end
                  rmsn_pkg::FPU_ADD: begin
                     sign_in = big.sign;
                     e_in    = big.e - 12'sd26;
                     mant_in = {29'd0, sum51};
                     if (ua.nan || ub.nan || (ua.inf && ub.inf && sx)) begin
                        res_in    = rmsn_pkg::CANON_NAN;
                        fstate_in = F_DONE;
                     end else if (ua.inf) begin
                        res_in    = fpu_req.a;
                        fstate_in = F_DONE;
                     end else if (ub.inf) begin
                        res_in    = fpu_req.b;
                        fstate_in = F_DONE;
                     end else if (ua.zero && ub.zero) begin
                        res_in    = {ua.sign & ub.sign, 31'd0};
                        fstate_in = F_DONE;
                     end else if (ua.zero) begin
                        res_in    = fpu_req.b;
                        fstate_in = F_DONE;
                     end else if (ub.zero) begin
                        res_in    = fpu_req.a;
                        fstate_in = F_DONE;
                     end else if (sum51 == 51'd0) begin
                        res_in    = rmsn_pkg::POS_ZERO;
                        fstate_in = F_DONE;
                     end
                  end
                  rmsn_pkg::FPU_DIV: begin
                     sign_in   = sx;
                     e_in      = ua.e - ub.e - 12'sd50;
                     mant_in   = 80'd0;
                     num_in    = {6'd0, ua.mant, 50'd0};
                     div_in    = ub.mant;
                     count_in  = DIV_STEPS;
                     fstate_in = F_ITER;
                     if (ua.nan || ub.nan || (ua.inf && ub.inf) || (ua.zero && ub.zero)) begin
                        res_in    = rmsn_pkg::CANON_NAN;
                        fstate_in = F_DONE;
                     end else if (ua.inf || ub.zero) begin
                        res_in    = {sx, rmsn_pkg::POS_INF[30:0]};
                        fstate_in = F_DONE;
                     end else if (ua.zero || ub.inf) begin
                        res_in    = {sx, 31'd0};
                        fstate_in = F_DONE;
                     end
                  end
                  rmsn_pkg::FPU_SQRT: begin
                     // Operand is positive, finite and nonzero here.
                     sign_in   = 1'b0;
                     e_in      = (sq_e - 12'sd52) >>> 1;
                     mant_in   = 80'd0;
                     num_in    = {3'd0, sq_mant, 52'd0};
                     count_in  = SQRT_STEPS;
                     fstate_in = F_ITER;
                  end
                  rmsn_pkg::FPU_I2F: begin
                     sign_in = 1'b0;
                     e_in    = 12'sd0;
                     mant_in = {48'd0, fpu_req.a};
                  end
                  default: begin
                     res_in    = rmsn_pkg::CANON_NAN;
                     fstate_in = F_DONE;
                  end
               endcase
            end
         end
         // One quotient bit or one root bit per cycle.
         F_ITER: begin
            rem_in   = ge ? (rem_sh - trial) : rem_sh;
            mant_in  = {mant_ff[78:0], ge};
            num_in   = is_sqrt_ff ? (num_ff << 2) : (num_ff << 1);
            count_in = count_ff - 7'd1;
            if (count_ff == 7'd1) begin
               sticky_in = (rem_in != 44'd0);
               fstate_in = F_NORM;
            end
         end
         // Shift that brings the leading one, or the subnormal limit, to bit 23 (negative: left shift).
         F_NORM: begin
            s_in      = (s_lead > s_sub) ? s_lead : s_sub;
            fstate_in = F_ROUND;
         end
         // Round to nearest even and pack.
         F_ROUND: begin
            if (mant_ff == 80'd0) begin
               res_in = {sign_ff, 31'd0};
            end else if (m25[24]) begin
               field  = fe + 14'sd1;
               res_in = {sign_ff, field[7:0], 23'd0};
            end else if (m25[23]) begin
               field  = fe;
               res_in = {sign_ff, field[7:0], m25[22:0]};
            end else begin
               res_in = {sign_ff, 8'd0, m25[22:0]};
            end
            if (field >= 14'sd255) begin
               res_in = {sign_ff, rmsn_pkg::POS_INF[30:0]};
            end
            fstate_in = F_DONE;
         end
         F_DONE: begin
            fstate_in = F_IDLE;
         end
         default: begin
            fstate_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= F_IDLE;
      end else begin
         fstate_ff <= fstate_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      sign_ff    <= sign_in;
      e_ff       <= e_in;
      mant_ff    <= mant_in;
      sticky_ff  <= sticky_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      is_sqrt_ff <= is_sqrt_in;
      count_ff   <= count_in;
      s_ff       <= s_in;
   end

   assign fpu_rsp.done   = (fstate_ff == F_DONE);
   assign fpu_rsp.result = res_ff;

   // A new operation only starts on an idle unit.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      fpu_req.start |-> fstate_ff == F_IDLE)
      else $error("fpu started while busy");

   // A result is offered for exactly one cycle.
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      fstate_ff == F_DONE |=> fstate_ff == F_IDLE)
      else $error("fpu result held for more than one cycle");

   // Iterations end with a normalise step.
   a_iter_end: assert property (@(posedge clock) disable iff (reset)
      (fstate_ff == F_ITER && count_ff == 7'd1) |=> fstate_ff == F_NORM)
      else $error("fpu iteration did not finish");

endmodule

### rtl/rmsn_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rmsn_back
// Sequences each queued item through the shared fp unit, keeps the row
// state and holds the result register.
// ============================================================================
module rmsn_back #(
   parameter int unsigned MAX_ROW_LEN = rmsn_pkg::MAX_ROW_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               queue_empty,
   input  rmsn_pkg::item_type                 head_item,
   output logic                               pop,
   input  logic [$clog2(MAX_ROW_LEN+1)-1:0]   row_len,
   input  logic                               data_format,
   input  logic [31:0]                        epsilon,
   output rmsn_pkg::fpu_req_type              fpu_req,
   input  rmsn_pkg::fpu_rsp_type              fpu_rsp,
   rmsn_rsp_if.source                         rsp_port
);

   localparam int unsigned LW = $clog2(MAX_ROW_LEN + 1);

   localparam logic [3:0] B_IDLE  = 4'd0;
   localparam logic [3:0] B_SQ    = 4'd1;
   localparam logic [3:0] B_ACC   = 4'd2;
   localparam logic [3:0] B_LEN   = 4'd3;
   localparam logic [3:0] B_MEAN  = 4'd4;
   localparam logic [3:0] B_EPS   = 4'd5;
   localparam logic [3:0] B_ROOT  = 4'd6;
   localparam logic [3:0] B_RECIP = 4'd7;
   localparam logic [3:0] B_GS    = 4'd8;
   localparam logic [3:0] B_XG    = 4'd9;
   localparam logic [3:0] B_OUT   = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic               issued_ff, issued_in;
   rmsn_pkg::item_type cur_ff, cur_in;
   logic [31:0]        t_ff, t_in;
   logic [31:0]        sum_ff, sum_in;
   logic [31:0]        scale_ff, scale_in;
   logic [LW-1:0]      accum_ff, accum_in;
   logic [LW-1:0]      norm_ff, norm_in;
   logic               last_ff, last_in;
   logic               out_valid_ff, out_valid_in;
   logic [31:0]        out_bits_ff, out_bits_in;
   logic               out_last_ff, out_last_in;

   logic [LW-1:0] accum_next, norm_next;
   logic          arith;
   logic [32:0]   bf_sum;
   logic [15:0]   bf_bits;
   logic [31:0]   r;

   assign accum_next = accum_ff + LW'(1);
   assign norm_next  = norm_ff + LW'(1);
   assign r          = fpu_rsp.result;

   // bf16 result, rounded to nearest even.
   assign bf_sum  = {1'b0, t_ff} + 33'h0_0000_7FFF + 33'(t_ff[16]);
   assign bf_bits = rmsn_pkg::is_nan(t_ff) ? rmsn_pkg::BF16_NAN : bf_sum[31:16];

   // Operand selection for the shared unit.
   always_comb begin
      arith       = 1'b1;
      fpu_req.op  = rmsn_pkg::FPU_MUL;
      fpu_req.a   = cur_ff.x;
      fpu_req.b   = cur_ff.x;
      unique case (state_ff)
         B_SQ: begin
            fpu_req.op = rmsn_pkg::FPU_MUL;
         end
         B_ACC: begin
            fpu_req.op = rmsn_pkg::FPU_ADD;
            fpu_req.a  = sum_ff;
            fpu_req.b  = t_ff;
         end
         B_LEN: begin
            fpu_req.op = rmsn_pkg::FPU_I2F;
            fpu_req.a  = 32'(row_len);
         end
         B_MEAN: begin
            fpu_req.op = rmsn_pkg::FPU_DIV;
            fpu_req.a  = sum_ff;
            fpu_req.b  = t_ff;
         end
         B_EPS: begin
            fpu_req.op = rmsn_pkg::FPU_ADD;
            fpu_req.a  = t_ff;
            fpu_req.b  = epsilon;
         end
         B_ROOT: begin
            fpu_req.op = rmsn_pkg::FPU_SQRT;
            fpu_req.a  = t_ff;
         end
         B_RECIP: begin
            fpu_req.op = rmsn_pkg::FPU_DIV;
            fpu_req.a  = rmsn_pkg::FP32_ONE;
            fpu_req.b  = t_ff;
         end
         B_GS: begin
            fpu_req.op = rmsn_pkg::FPU_MUL;
            fpu_req.a  = cur_ff.gamma;
            fpu_req.b  = scale_ff;
         end
         B_XG: begin
            fpu_req.op = rmsn_pkg::FPU_MUL;
            fpu_req.b  = t_ff;
         end
         default: begin
            arith = 1'b0;
         end
      endcase
      fpu_req.start = arith && !issued_ff;
   end

   // Item sequencer.
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      cur_in       = cur_ff;
      t_in         = t_ff;
      sum_in       = sum_ff;
      scale_in     = scale_ff;
      accum_in     = accum_ff;
      norm_in      = norm_ff;
      last_in      = last_ff;
      out_bits_in  = out_bits_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      pop          = 1'b0;

      if (fpu_req.start) begin
         issued_in = 1'b1;
      end
      if (fpu_rsp.done) begin
         issued_in = 1'b0;
         t_in      = r;
      end

      unique case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               cur_in = head_item;
               state_in = (head_item.operation == rmsn_pkg::OP_NORMALIZE) ? B_GS : B_SQ;
            end
         end
         B_SQ: begin
            if (fpu_rsp.done) begin
               state_in = B_ACC;
            end
         end
         B_ACC: begin
            if (fpu_rsp.done) begin
               sum_in = r;
               if (accum_next >= row_len) begin
                  accum_in = '0;
                  state_in = B_LEN;
               end else begin
                  accum_in = accum_next;
                  state_in = B_IDLE;
               end
            end
         end
         B_LEN: begin
            if (fpu_rsp.done) begin
               state_in = B_MEAN;
            end
         end
         B_MEAN: begin
            if (fpu_rsp.done) begin
               sum_in   = rmsn_pkg::POS_ZERO;
               state_in = B_EPS;
            end
         end
         // Square root specials are settled here.
         B_EPS: begin
            if (fpu_rsp.done) begin
               state_in = B_IDLE;
               priority if (rmsn_pkg::is_nan(r)) begin
                  scale_in = rmsn_pkg::CANON_NAN;
               end else if (r == rmsn_pkg::POS_ZERO) begin
                  scale_in = rmsn_pkg::POS_INF;
               end else if (r == rmsn_pkg::NEG_ZERO) begin
                  scale_in = rmsn_pkg::NEG_INF;
               end else if (r[31]) begin
                  scale_in = rmsn_pkg::CANON_NAN;
               end else if (r == rmsn_pkg::POS_INF) begin
                  scale_in = rmsn_pkg::POS_ZERO;
               end else begin
                  state_in = B_ROOT;
               end
            end
         end
         B_ROOT: begin
            if (fpu_rsp.done) begin
               state_in = B_RECIP;
            end
         end
         B_RECIP: begin
            if (fpu_rsp.done) begin
               scale_in = r;
               state_in = B_IDLE;
            end
         end
         B_GS: begin
            if (fpu_rsp.done) begin
               state_in = B_XG;
            end
         end
         B_XG: begin
            if (fpu_rsp.done) begin
               last_in  = (norm_next >= row_len);
               norm_in  = (norm_next >= row_len) ? '0 : norm_next;
               state_in = B_OUT;
            end
         end
         // Load the result register once it is free.
         B_OUT: begin
            if (!out_valid_ff || rsp_port.ready) begin
               out_valid_in = 1'b1;
               out_last_in  = last_ff;
               if (data_format == rmsn_pkg::FORMAT_BF16) begin
                  out_bits_in = {16'h0000, bf_bits};
               end else begin
                  out_bits_in = t_ff;
               end
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         issued_ff    <= 1'b0;
         sum_ff       <= rmsn_pkg::POS_ZERO;
         scale_ff     <= rmsn_pkg::FP32_ONE;
         accum_ff     <= '0;
         norm_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         sum_ff       <= sum_in;
         scale_ff     <= scale_in;
         accum_ff     <= accum_in;
         norm_ff      <= norm_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      t_ff        <= t_in;
      last_ff     <= last_in;
      out_bits_ff <= out_bits_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.result_bits = out_bits_ff;
   assign rsp_port.row_last    = out_last_ff;

   // A result only appears from the output step.
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == B_OUT))
      else $error("result appeared outside the output step");

   // A popped item starts one of the two operation sequences.
   a_pop_start: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == B_SQ || state_ff == B_GS))
      else $error("popped item not started");

   // Row counters stay below the configured maximum.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (32'(accum_ff) < MAX_ROW_LEN) && (32'(norm_ff) < MAX_ROW_LEN))
      else $error("row index out of range");

endmodule

### rtl/rms_norm_row.sv
`timescale 1ns / 1ps
// ============================================================================
// rms_norm_row
// RMS normalisation of rows: accumulate squares, then scale each element by
// gamma * rsqrt(mean square + epsilon). Elements in fp32 or bf16.
// ============================================================================
//
//  channel   role     ports              payload
//  --------  -------  -----------------  ----------------------------------
//  request   sink     req_port           operation, element_bits, gamma_bits
//  result    source   rsp_port           result_bits, row_last
//  config    slave    psel ... prdata    row_length, data_format, epsilon_bits
//
// Each accumulate or normalise item makes two passes through the shared fp unit
// (set-up, normalise, round, hand-over), and a normalise item then loads the
// result register. A zero, infinite or NaN operand cuts a pass to set-up and
// hand-over. The row's last accumulate item adds further passes, among them
// the two bit-serial 80-step divides and the 40-step square root.
// Reset is synchronous and active high; there is no clearing pass.
// A two-entry queue takes items while the back is busy, and the result
// register lets the back move on while a result waits to be taken.
//
module rms_norm_row #(
   parameter int unsigned MAX_ROW_LEN = rmsn_pkg::MAX_ROW_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rmsn_req_if.sink    req_port,
   rmsn_rsp_if.source  rsp_port,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned LW = $clog2(MAX_ROW_LEN + 1);

   logic [16:0] row_length_ff;
   logic        data_format_ff;
   logic [31:0] epsilon_ff;
   logic        csr_write;
   logic [31:0] rl_wide, len_wide;
   logic [LW-1:0] row_len;

   logic               push, pop, q_full, q_empty;
   rmsn_pkg::item_type push_item, head_item;
   rmsn_pkg::fpu_req_type fpu_req;
   rmsn_pkg::fpu_rsp_type fpu_rsp;

   // Register writes.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= rmsn_pkg::ROW_LENGTH_RESET;
         data_format_ff <= rmsn_pkg::FORMAT_FP32;
         epsilon_ff     <= rmsn_pkg::EPSILON_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            rmsn_pkg::REG_ROW_LENGTH:  row_length_ff  <= pwdata[16:0];
            rmsn_pkg::REG_DATA_FORMAT: data_format_ff <= pwdata[0];
            rmsn_pkg::REG_EPSILON:     epsilon_ff     <= pwdata;
            default: begin
            end
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (paddr[3:2])
         rmsn_pkg::REG_ROW_LENGTH:  prdata = {15'd0, row_length_ff};
         rmsn_pkg::REG_DATA_FORMAT: prdata = {31'd0, data_format_ff};
         rmsn_pkg::REG_EPSILON:     prdata = epsilon_ff;
         default:                   prdata = 32'd0;
      endcase
   end

   // Effective row length: zero counts as one, capped at the maximum.
   assign rl_wide = 32'(row_length_ff);
   always_comb begin
      if (rl_wide == 32'd0) begin
         len_wide = 32'd1;
      end else if (rl_wide > 32'(MAX_ROW_LEN)) begin
         len_wide = 32'(MAX_ROW_LEN);
      end else begin
         len_wide = rl_wide;
      end
   end
   assign row_len = len_wide[LW-1:0];

   rmsn_front u_front (
      .req_port    (req_port),
      .data_format (data_format_ff),
      .queue_full  (q_full),
      .push        (push),
      .push_item   (push_item)
   );

   rmsn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_item (head_item)
   );

   rmsn_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   rmsn_back #(
      .MAX_ROW_LEN (MAX_ROW_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .head_item   (head_item),
      .pop         (pop),
      .row_len     (row_len),
      .data_format (data_format_ff),
      .epsilon     (epsilon_ff),
      .fpu_req     (fpu_req),
      .fpu_rsp     (fpu_rsp),
      .rsp_port    (rsp_port)
   );

endmodule

### dv/rms_norm_row_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// rms_norm_row_tb
// Self-checking bench for the RMS row normaliser. Rows of squares are summed
// and then scaled, over many register settings in fp32 and bf16. An fp32
// predictor works out each result, and results are checked in order.
// ============================================================================
module rms_norm_row_tb;

   localparam int LIMIT      = 3000000;
   localparam int SETTLE_CYC = 1000;

   typedef struct {
      logic        operation;
      logic [31:0] element;
      logic [31:0] gain;
   } norm_item_type;

   typedef struct {
      logic [31:0] value;
      logic        last;
   } norm_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   rmsn_req_if req_ch ();
   rmsn_rsp_if rsp_ch ();

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = rmsn_pkg::OP_ACCUMULATE;
      req_ch.element_bits = '0;
      req_ch.gamma_bits = '0;
      rsp_ch.ready = 1'b0;
   end

   rms_norm_row uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   norm_item_type   pending_items[$];
   norm_result_type expected_results[$];
   int              cycle_count = 0;
   int              fail_count = 0;

   // Predictor copy of the registers and the row state.
   logic [16:0] row_len_reg = rmsn_pkg::ROW_LENGTH_RESET;
   logic        format_reg = rmsn_pkg::FORMAT_FP32;
   logic [31:0] epsilon_reg = rmsn_pkg::EPSILON_RESET;
   logic [31:0] sum_of_squares = rmsn_pkg::POS_ZERO;
   logic [31:0] row_scale = rmsn_pkg::FP32_ONE;
   int          accum_count = 0;
   int          norm_count = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // fp32 arithmetic through doubles. Double precision holds more than
   // twice the fp32 significand, so rounding twice gives the same answer.
   // ------------------------------------------------------------------
   function automatic real widen(input logic [31:0] f);
      real r;
      if (f[30:23] == 8'hFF)
         return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
      if (f[30:23] == 8'h00) begin
         if (f[22:0] == 0)
            return $bitstoreal({f[31], 63'd0});
         r = $itor(f[22:0]) * (2.0 ** (-149));
         return f[31] ? -r : r;
      end
      return $bitstoreal({f[31], 11'(f[30:23] - 127 + 1023), f[22:0], 29'd0});
   endfunction

   function automatic logic [31:0] narrow(input real v);
      logic [63:0] d, sig, kept, rest, half;
      int          fe, sh;
      d = $realtobits(v);
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? rmsn_pkg::CANON_NAN : {d[63], 31'h7F800000};
      if (d[62:52] == 0)
         return {d[63], 31'd0};
      fe = int'(d[62:52]) - 1023 + 127;
      sig = {11'd0, 1'b1, d[51:0]};
      sh = (fe >= 1) ? 29 : 30 - fe;
      if (sh > 60)
         return {d[63], 31'd0};
      kept = sig >> sh;
      rest = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rest > half || (rest == half && kept[0]))
         kept = kept + 1;
      if (fe < 1)
         return {d[63], kept[30:0]};
      if (kept[24]) begin
         kept = kept >> 1;
         fe = fe + 1;
      end
      if (fe >= 255)
         return {d[63], 31'h7F800000};
      return {d[63], 8'(fe), kept[22:0]};
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      return narrow(widen(a) * widen(b));
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      return narrow(widen(a) + widen(b));
   endfunction

   function automatic logic [31:0] fdiv(input logic [31:0] a, input logic [31:0] b);
      return narrow(widen(a) / widen(b));
   endfunction

   // Reciprocal square root with the special cases of the block.
   function automatic logic [31:0] inv_root(input logic [31:0] m);
      if (rmsn_pkg::is_nan(m))
         return rmsn_pkg::CANON_NAN;
      if (m == rmsn_pkg::POS_ZERO)
         return rmsn_pkg::POS_INF;
      if (m == rmsn_pkg::NEG_ZERO)
         return rmsn_pkg::NEG_INF;
      if (m[31])
         return rmsn_pkg::CANON_NAN;
      if (m == rmsn_pkg::POS_INF)
         return rmsn_pkg::POS_ZERO;
      return fdiv(rmsn_pkg::FP32_ONE, narrow($sqrt(widen(m))));
   endfunction

   function automatic logic [15:0] round_bf16(input logic [31:0] b);
      logic [32:0] s;
      if (rmsn_pkg::is_nan(b))
         return rmsn_pkg::BF16_NAN;
      s = {1'b0, b} + 33'h7FFF + b[16];
      return s[31:16];
   endfunction

   // Works out the effect of one accepted item on the row state.
   function automatic void predict_row(input norm_item_type it);
      int              len;
      logic [31:0]     x, y, mean;
      norm_result_type res;
      len = (row_len_reg == 0) ? 1 :
            (row_len_reg > rmsn_pkg::MAX_ROW_LEN_DEFAULT) ?
            rmsn_pkg::MAX_ROW_LEN_DEFAULT : int'(row_len_reg);
      x = (format_reg == rmsn_pkg::FORMAT_BF16) ? {it.element[15:0], 16'h0} : it.element;
      if (it.operation == rmsn_pkg::OP_ACCUMULATE) begin
         sum_of_squares = fadd(sum_of_squares, fmul(x, x));
         accum_count++;
         if (accum_count >= len) begin
            mean = fdiv(sum_of_squares, narrow($itor(len)));
            row_scale = inv_root(fadd(mean, epsilon_reg));
            sum_of_squares = rmsn_pkg::POS_ZERO;
            accum_count = 0;
         end
      end else begin
         y = fmul(x, fmul(it.gain, row_scale));
         norm_count++;
         res.last = (norm_count >= len);
         if (res.last)
            norm_count = 0;
         res.value = (format_reg == rmsn_pkg::FORMAT_BF16) ? {16'h0, round_bf16(y)} : y;
         expected_results.push_back(res);
      end
   endfunction

   // Idling at about 18 in 100, none in a quiet stretch of the run.
   function automatic logic take_gap();
      if (cycle_count > 4000 && cycle_count < 9000)
         return 1'b0;
      return ($urandom_range(0, 99) < 18);
   endfunction

   // Request driver.
   norm_item_type next_item;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_items.size() != 0 && !take_gap()) begin
            next_item = pending_items.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.operation <= next_item.operation;
            req_ch.element_bits <= next_item.element;
            req_ch.gamma_bits <= next_item.gain;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result back-pressure.
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= !take_gap();
   end

   // Monitor: register writes, accepted items and accepted results.
   norm_item_type   seen_item;
   norm_result_type want;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("rms_norm_row verification failed");
         $finish;
      end
      if (!reset && psel && penable && pwrite && pready) begin
         case (paddr[3:2])
            rmsn_pkg::REG_ROW_LENGTH: begin
               row_len_reg = pwdata[16:0];
            end
            rmsn_pkg::REG_DATA_FORMAT: begin
               format_reg = pwdata[0];
            end
            rmsn_pkg::REG_EPSILON: begin
               epsilon_reg = pwdata;
            end
            default: begin
            end
         endcase
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result %h last %b", rsp_ch.result_bits, rsp_ch.row_last);
         end else begin
            want = expected_results.pop_front();
            if (want.value !== rsp_ch.result_bits || want.last !== rsp_ch.row_last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result mismatch: expected %h last %b, got %h last %b",
                           want.value, want.last, rsp_ch.result_bits, rsp_ch.row_last);
            end
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         seen_item.operation = req_ch.operation;
         seen_item.element = req_ch.element_bits;
         seen_item.gain = req_ch.gamma_bits;
         predict_row(seen_item);
      end
   end

   // Setup and access cycles of one register write.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_all(input logic [16:0] len, input logic fmt, input logic [31:0] eps);
      write_reg(rmsn_pkg::REG_ROW_LENGTH, {15'd0, len});
      write_reg(rmsn_pkg::REG_DATA_FORMAT, {31'd0, fmt});
      write_reg(rmsn_pkg::REG_EPSILON, eps);
   endtask

   // Holds the sender until every result is in and the block has settled.
   task automatic drain();
      while (pending_items.size() != 0 || expected_results.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic add_item(input logic op, input logic [31:0] e, input logic [31:0] g);
      norm_item_type it;
      it.operation = op;
      it.element = e;
      it.gain = g;
      pending_items.push_back(it);
   endtask

   // A value of moderate size, with occasional raw bits or specials.
   function automatic logic [31:0] pick_value(input int lo_exp, input int hi_exp);
      int k;
      k = $urandom_range(0, 19);
      if (k < 2)
         return $urandom;
      if (k == 2) begin
         case ($urandom_range(0, 4))
            0: return rmsn_pkg::POS_ZERO;
            1: return rmsn_pkg::NEG_ZERO;
            2: return rmsn_pkg::POS_INF;
            3: return 32'h7FFFFFFF;
            default: return 32'h00000001;
         endcase
      end
      return {1'($urandom), 8'($urandom_range(lo_exp, hi_exp)), 23'($urandom)};
   endfunction

   // Places a value where the current format reads it.
   function automatic logic [31:0] as_element(input logic fmt, input logic [31:0] v);
      return (fmt == rmsn_pkg::FORMAT_BF16) ? {16'($urandom), v[31:16]} : v;
   endfunction

   int          phase_items, rows_len;
   logic        fmt;
   logic [31:0] eps;
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Normalising before any scale is set uses the reset scale of one.
      add_item(rmsn_pkg::OP_NORMALIZE, rmsn_pkg::POS_ZERO, rmsn_pkg::FP32_ONE);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'hFFFFFFFF, 32'hFFFFFFFF);
      add_item(rmsn_pkg::OP_NORMALIZE, rmsn_pkg::POS_INF, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'h7F7FFFFF, 32'h7F7FFFFF);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'h00000001, 32'h80000001);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h3F800000, 32'hFFFFFFFF);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h40000000, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'hC0400000, rmsn_pkg::POS_ZERO);
      drain();

      // Shorter row than the count so far: the next element closes it.
      set_all(17'd2, rmsn_pkg::FORMAT_FP32, rmsn_pkg::EPSILON_RESET);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h3F800000, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'h3F800000, 32'h3F800000);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'hBF800000, 32'h40000000);
      drain();

      // Row length zero acts as one; zero mean square gives infinite scale.
      set_all(17'd0, rmsn_pkg::FORMAT_FP32, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_ACCUMULATE, rmsn_pkg::POS_ZERO, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'h3F800000, 32'h3F800000);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h7F7FFFFF, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'h3F800000, 32'h3F800000);
      drain();

      // Negative and NaN epsilon, then bf16 extremes.
      set_all(17'd1, rmsn_pkg::FORMAT_FP32, 32'hBF800000);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h3A000000, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'h3F800000, 32'h3F800000);
      drain();
      set_all(17'd1, rmsn_pkg::FORMAT_BF16, 32'h7FC00001);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h00003F80, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'hFFFF7F7F, 32'h3F800000);
      drain();

      // Over-long row length saturates; then a short row ends it early.
      set_all(17'h1FFFF, rmsn_pkg::FORMAT_BF16, rmsn_pkg::EPSILON_RESET);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h0000FFFF, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h00004000, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'hFFFF3F80, rmsn_pkg::POS_ZERO);
      add_item(rmsn_pkg::OP_NORMALIZE, 32'h00003F80, 32'h3F800000);
      drain();
      set_all(17'd65536, rmsn_pkg::FORMAT_FP32, rmsn_pkg::EPSILON_RESET);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h3F800000, rmsn_pkg::POS_ZERO);
      drain();
      set_all(17'd3, rmsn_pkg::FORMAT_FP32, rmsn_pkg::EPSILON_RESET);
      add_item(rmsn_pkg::OP_ACCUMULATE, 32'h3F800000, rmsn_pkg::POS_ZERO);
      drain();

      // Random phases: mostly whole rows, with some stray items between.
      for (int p = 0; p < 15; p++) begin
         case ($urandom_range(0, 3))
            0: rows_len = $urandom_range(1, 3);
            1: rows_len = $urandom_range(4, 16);
            2: rows_len = $urandom_range(17, 40);
            default: rows_len = (p % 2) ? 1 : 16;
         endcase
         fmt = 1'($urandom);
         case ($urandom_range(0, 4))
            0: eps = rmsn_pkg::POS_ZERO;
            1: eps = $urandom;
            2: eps = 32'hFFFFFFFF;
            default: eps = {2'b00, 6'($urandom_range(10, 40)), 24'($urandom)};
         endcase
         set_all(17'(rows_len), fmt, eps);
         phase_items = 0;
         while (phase_items < 90) begin
            if ($urandom_range(0, 9) == 0) begin
               add_item(1'($urandom), as_element(fmt, pick_value(90, 160)), pick_value(110, 140));
               phase_items++;
            end else begin
               for (int i = 0; i < rows_len; i++)
                  add_item(rmsn_pkg::OP_ACCUMULATE, as_element(fmt, pick_value(100, 150)),
                           $urandom);
               for (int i = 0; i < rows_len; i++)
                  add_item(rmsn_pkg::OP_NORMALIZE, as_element(fmt, pick_value(100, 150)),
                           pick_value(115, 135));
               phase_items += 2 * rows_len;
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("rms_norm_row verification clean");
      end else begin
         $display("rms_norm_row verification failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/rmsn_pkg.sv
rtl/rmsn_channels.sv
rtl/rmsn_front.sv
rtl/rmsn_queue.sv
rtl/rmsn_fpu.sv
rtl/rmsn_back.sv
rtl/rms_norm_row.sv
dv/rms_norm_row_tb.sv
